// File: hdl/positional_list_engine_defines.svh
// ----------------------------------------------------------------------------
// positional_list_engine_defines.svh
// assertion macros for the positional list engine, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define PLE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// checked at every edge, reset included
`define PLE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define PLE_ASSERT(lbl, prop)
`define PLE_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: hdl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// operation and status codes of the positional list engine
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
  localparam logic [OP_W-1:0] OP_READ_OUT  = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

  // kind of walk over the entry memory
  typedef enum logic [1:0] {
    K_INS = 2'd0,
    K_DEL = 2'd1,
    K_RD  = 2'd2
  } kind_t;

endpackage

`default_nettype wire

// File: hdl/ple_ram.sv
// ----------------------------------------------------------------------------
// ple_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// ordered list of signed 32-bit values kept in one entry ram
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low; every result is
// shown for one cycle with out_strobe and cannot be held off, out_is_last
// marks the final result of an operation. Entries sit packed in list order
// in a ram with one read and one write port, so an edit in the middle moves
// the tail one entry per cycle through that ram. With n entries, read out
// gives n transfers, one per cycle. Any error or an insert at the back is
// answered from idle without a walk, and an ignored code gives no result.
// The single ram port pair sets this pace. No clearing pass runs after
// reset: entries are read only once written.
`default_nettype none

`include "positional_list_engine_defines.svh"

module positional_list_engine #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [ple_pkg::OP_W-1:0]         in_operation,
  input  wire logic signed [ple_pkg::VALUE_W-1:0] in_value,
  input  wire logic [ple_pkg::POS_W-1:0]        in_position,
  output logic                                  out_strobe,
  output logic [ple_pkg::STATUS_W-1:0]          out_status,
  output logic signed [ple_pkg::VALUE_W-1:0]    out_entry_value,
  output logic                                  out_is_last,
  output logic [ple_pkg::COUNT_W-1:0]           out_entry_count
);

  import ple_pkg::*;

  // widths: address into the ram, occupancy, position compare
  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  // one-hot sequencer
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WALK  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  kind_t  kind_r, kind_nxt;

  logic [CW-1:0]      occ_r, occ_nxt;
  logic [AW-1:0]      cur_r, cur_nxt;     // address being read this cycle
  logic [AW-1:0]      end_r, end_nxt;     // last address of the walk / slot
  logic               first_r, first_nxt; // first read of a delete is the victim
  logic [VALUE_W-1:0] val_r, val_nxt;     // value to insert
  logic [VALUE_W-1:0] hold_r, hold_nxt;   // value removed

  // action pending on the read data that lands this cycle
  logic          pw_r, pw_nxt;  // write it back one place over
  logic          pc_r, pc_nxt;  // capture it as removed value
  logic          pe_r, pe_nxt;  // send it out as a read-out transfer
  logic          pl_r, pl_nxt;  // that transfer is the last one
  logic [AW-1:0] wa_r, wa_nxt;

  // output registers
  logic                strobe_r, strobe_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [VALUE_W-1:0]  evalue_r, evalue_nxt;
  logic                last_r, last_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;

  // ram ports
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  // decode helpers
  logic            accept;
  logic [CMPW-1:0] pos_c, occ_c, slot_c;
  logic            is_ins, is_del, ins_bad, del_bad, full, empty;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign pos_c = CMPW'(in_position);
  assign occ_c = CMPW'(occ_r);
  assign full  = (occ_c == CMPW'(CAPACITY));
  assign empty = (occ_r == '0);

  assign is_ins = (in_operation == OP_INS_FRONT) || (in_operation == OP_INS_BACK) ||
                  (in_operation == OP_INS_AT);
  assign is_del = (in_operation == OP_DEL_FRONT) || (in_operation == OP_DEL_BACK) ||
                  (in_operation == OP_DEL_AT);

  // position 0 or past the end is rejected for the positional forms only
  assign ins_bad = (in_operation == OP_INS_AT) &&
                   ((pos_c == '0) || (pos_c > occ_c + CMPW'(1)));
  assign del_bad = (in_operation == OP_DEL_AT) &&
                   ((pos_c == '0) || (pos_c > occ_c));

  // 0-based slot the operation touches, valid only when the checks pass
  always_comb begin
    unique case (in_operation)
      OP_INS_FRONT, OP_DEL_FRONT: slot_c = '0;
      OP_INS_BACK:                slot_c = occ_c;
      OP_DEL_BACK:                slot_c = occ_c - CMPW'(1);
      default:                    slot_c = pos_c - CMPW'(1);
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    occ_nxt    = occ_r;
    cur_nxt    = cur_r;
    end_nxt    = end_r;
    first_nxt  = first_r;
    val_nxt    = val_r;
    hold_nxt   = hold_r;
    pw_nxt     = 1'b0;
    pc_nxt     = 1'b0;
    pe_nxt     = 1'b0;
    pl_nxt     = 1'b0;
    wa_nxt     = wa_r;
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    evalue_nxt = evalue_r;
    last_nxt   = last_r;
    count_nxt  = count_r;
    ram_we     = 1'b0;
    ram_waddr  = wa_r;
    ram_wdata  = ram_rdata;
    ram_raddr  = cur_r;

    // finish the action on the read data arriving now
    if (pw_r) begin
      ram_we = 1'b1;
    end
    if (pc_r) begin
      hold_nxt = ram_rdata;
    end
    if (pe_r) begin
      strobe_nxt = 1'b1;
      status_nxt = ST_OK;
      evalue_nxt = ram_rdata;
      last_nxt   = pl_r;
      count_nxt  = COUNT_W'(occ_r);
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt   = in_value;
          last_nxt  = 1'b1;
          count_nxt = COUNT_W'(occ_r);
          if (is_ins) begin
            evalue_nxt = in_value;
            if (ins_bad) begin
              strobe_nxt = 1'b1;
              status_nxt = ST_BADPOS;
            end else if (full) begin
              strobe_nxt = 1'b1;
              status_nxt = ST_FULL;
            end else if (slot_c == occ_c) begin
              // append: nothing to move
              ram_we     = 1'b1;
              ram_waddr  = AW'(occ_r);
              ram_wdata  = in_value;
              occ_nxt    = occ_r + CW'(1);
              strobe_nxt = 1'b1;
              status_nxt = ST_OK;
              count_nxt  = COUNT_W'(occ_nxt);
            end else begin
              // move the tail up, last entry first
              kind_nxt  = K_INS;
              cur_nxt   = AW'(occ_r - CW'(1));
              end_nxt   = AW'(slot_c);
              state_nxt = S_WALK;
            end
          end else if (is_del) begin
            evalue_nxt = '0;
            if (empty) begin
              strobe_nxt = 1'b1;
              status_nxt = ST_EMPTY;
            end else if (del_bad) begin
              strobe_nxt = 1'b1;
              status_nxt = ST_BADPOS;
            end else begin
              // read the victim, then move the tail down
              kind_nxt  = K_DEL;
              cur_nxt   = AW'(slot_c);
              end_nxt   = AW'(occ_r - CW'(1));
              first_nxt = 1'b1;
              state_nxt = S_WALK;
            end
          end else if (in_operation == OP_READ_OUT) begin
            evalue_nxt = '0;
            if (empty) begin
              strobe_nxt = 1'b1;
              status_nxt = ST_EMPTY;
            end else begin
              kind_nxt  = K_RD;
              cur_nxt   = '0;
              end_nxt   = AW'(occ_r - CW'(1));
              state_nxt = S_WALK;
            end
          end
        end
      end
      S_WALK: begin
        unique case (kind_r)
          K_INS: begin
            pw_nxt = 1'b1;
            wa_nxt = cur_r + AW'(1);
          end
          K_DEL: begin
            first_nxt = 1'b0;
            if (first_r) begin
              pc_nxt = 1'b1;
            end else begin
              pw_nxt = 1'b1;
              wa_nxt = cur_r - AW'(1);
            end
          end
          default: begin
            pe_nxt = 1'b1;
            pl_nxt = (cur_r == end_r);
          end
        endcase
        if (cur_r == end_r) begin
          state_nxt = S_DRAIN;
        end else if (kind_r == K_INS) begin
          cur_nxt = cur_r - AW'(1);
        end else begin
          cur_nxt = cur_r + AW'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = (kind_r == K_RD) ? S_IDLE : S_DONE;
      end
      default: begin
        // S_DONE: close the edit and report it
        strobe_nxt = 1'b1;
        status_nxt = ST_OK;
        last_nxt   = 1'b1;
        state_nxt  = S_IDLE;
        if (kind_r == K_INS) begin
          ram_we     = 1'b1;
          ram_waddr  = end_r;
          ram_wdata  = val_r;
          occ_nxt    = occ_r + CW'(1);
          evalue_nxt = val_r;
        end else begin
          occ_nxt    = occ_r - CW'(1);
          evalue_nxt = hold_r;
        end
        count_nxt = COUNT_W'(occ_nxt);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      occ_r    <= '0;
      pw_r     <= 1'b0;
      pc_r     <= 1'b0;
      pe_r     <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      occ_r    <= occ_nxt;
      pw_r     <= pw_nxt;
      pc_r     <= pc_nxt;
      pe_r     <= pe_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    cur_r    <= cur_nxt;
    end_r    <= end_nxt;
    first_r  <= first_nxt;
    val_r    <= val_nxt;
    hold_r   <= hold_nxt;
    pl_r     <= pl_nxt;
    wa_r     <= wa_nxt;
    status_r <= status_nxt;
    evalue_r <= evalue_nxt;
    last_r   <= last_nxt;
    count_r  <= count_nxt;
  end

  ple_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_entry_value = evalue_r;
  assign out_is_last     = last_r;
  assign out_entry_count = count_r;

  // occupancy never passes the capacity
  `PLE_ASSERT(a_occ_bound, CMPW'(occ_r) <= CMPW'(CAPACITY))
  // nothing pending on ram data once back in idle
  `PLE_ASSERT(a_idle_clean, (state_r == S_IDLE) |-> (!pw_r && !pc_r && !pe_r))
  // a transfer always follows an accepted operation or running work
  `PLE_ASSERT(a_strobe_cause, out_strobe |-> $past(accept || busy))
  // occupancy moves only together with a reported transfer
  `PLE_ASSERT(a_occ_reported, ($past(rst_n) && (occ_r != $past(occ_r))) |-> out_strobe)
  // the ram is never written while idle and nothing was accepted
  `PLE_ASSERT_ALWAYS(a_no_stray_write, (rst_n && !busy && !accept) |-> !ram_we)

endmodule

`default_nettype wire
